// ===== sv/lbp3_pkg.sv =====
`timescale 1ns / 1ps

package lbp3_pkg;

    // sizes fixed by the stream and register formats
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int PIX_W         = 8;
    localparam int CODE_W        = 8;
    localparam int CFG_WIDTH_W   = 12;
    localparam int CFG_HEIGHT_W  = 16;
    localparam int ROW_W         = CFG_HEIGHT_W + 1;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    // register reset values
    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    // register index (byte address / 4)
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    // frame size as programmed
    typedef struct packed {
        logic [CFG_WIDTH_W-1:0]  image_width;
        logic [CFG_HEIGHT_W-1:0] image_height;
    } t_cfg;

endpackage

// ===== sv/lbp3_pix_if.sv =====
`timescale 1ns / 1ps

interface lbp3_pix_if import lbp3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, func, pixel, input ready);
    modport sink   (input valid, func, pixel, output ready);
endinterface

// ===== sv/lbp3_code_if.sv =====
`timescale 1ns / 1ps

interface lbp3_code_if import lbp3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] lbp_code;
    logic              frame_last;

    modport source (output valid, lbp_code, frame_last, input ready);
    modport sink   (input valid, lbp_code, frame_last, output ready);
endinterface

// ===== sv/lbp3_apb_regs.sv =====
`timescale 1ns / 1ps

module lbp3_apb_regs import lbp3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    t_reg_idx                reg_idx;
    logic                    wr_stb;

    // no wait states
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_stb  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (wr_stb) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  r_width  <= pwdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.image_width  = r_width;
    assign o_cfg.image_height = r_height;

endmodule

// ===== sv/lbp3_line_buf.sv =====
`timescale 1ns / 1ps

module lbp3_line_buf import lbp3_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [CW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [CW-1:0] i_wr_addr,
    input  t_pix          i_wr_up,
    input  t_pix          i_wr_mid,
    output t_pix          o_up_rd,
    output t_pix          o_mid_rd
);

    // two previous rows, one entry per column
    t_pix r_up_mem  [MAX_WIDTH];
    t_pix r_mid_mem [MAX_WIDTH];
    t_pix r_up_rd;
    t_pix r_mid_rd;

    // one write and one registered read per cycle; a read of the column
    // being written takes the new data (single-column frames)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_up_mem[i_wr_addr]  <= i_wr_up;
            r_mid_mem[i_wr_addr] <= i_wr_mid;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_up_rd  <= i_wr_up;
                r_mid_rd <= i_wr_mid;
            end else begin
                r_up_rd  <= r_up_mem[i_rd_addr];
                r_mid_rd <= r_mid_mem[i_rd_addr];
            end
        end
    end

    assign o_up_rd  = r_up_rd;
    assign o_mid_rd = r_mid_rd;

endmodule

// ===== sv/lbp_3x3_image_stream.sv =====
`timescale 1ns / 1ps

// 3x3 local binary pattern over a raster pixel stream.
// i_pix: valid/ready input; func=0 carries a pixel, func=1 is a flush tick.
// o_code: valid/ready output with the 8-bit code (bit 7 top-left, clockwise
// to bit 0 left) and frame_last on the last code of the frame.
// Frame size comes from the APB registers image_width (0x0) and
// image_height (0x4); it is latched at the first pixel of each frame.
// The code of pixel n belongs to input transfer n + width + 1; after the
// last pixel, width + 1 flush transfers drain the rest. Flush ticks inside a
// frame or while idle are dropped; pixels during the drain act as flushes.
// A code reaches o_code through the input register, then the result
// register, after the input transfer that completes it.
// Throughput: one transfer per cycle while o_code is not stalled; the line
// buffers give one read and one write per cycle.
// Reset clears position counters, window and output valid; line buffers are
// not cleared (their unwritten entries only feed masked positions).
// When the receiver stalls, the result register holds its code and the
// input register keeps one more item, then i_pix.ready drops.

module lbp_3x3_image_stream import lbp3_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    lbp3_pix_if.sink              i_pix,
    lbp3_code_if.source           o_code
);

    localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW        = $clog2(MAX_WIDTH + 1);
    localparam int ACT_W_RST = (MAX_WIDTH < int'(WIDTH_RESET)) ? MAX_WIDTH
                                                               : int'(WIDTH_RESET);

    // control bits carried with an item in the input register
    typedef struct packed {
        logic case_a;   // column 0: code of the last pixel two rows up
        logic case_b;   // inner column: code of the pixel one row up, one to the left
        logic hl;       // left neighbors inside the frame
        logic ht;       // top neighbors inside the frame
        logic last;     // last code of the frame
    } t_s1_ctrl;

    t_cfg cfg;

    // frame position and latched size
    logic [ROW_W-1:0]        r_in_row, n_in_row;
    logic [CW-1:0]           r_in_col, n_in_col;
    logic [AW-1:0]           r_act_w;
    logic [CFG_HEIGHT_W-1:0] r_act_h;

    // input register
    logic     r_s1_valid;
    t_s1_ctrl r_s1;
    t_pix     r_s1_pix;
    logic [CW-1:0] r_s1_col;

    // window and result register
    t_pix              r_win [3][3];
    logic              r_out_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_last;

    logic [AW-1:0]           lat_w, cur_w, col_p1;
    logic [CFG_HEIGHT_W-1:0] lat_h, cur_h;
    logic                    in_frame, skip, do_latch, acc, s1_go, s1_adv, s1_emit;
    t_s1_ctrl                ctrl;
    t_pix                    pix_in, lb_up_rd, lb_mid_rd, ctr;
    t_pix [7:0]              nb;
    logic [CODE_W-1:0]       code;

    lbp3_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // size as it would be latched now, clamped to the legal range
    always_comb begin
        if (cfg.image_width == '0) begin
            lat_w = AW'(1);
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            lat_w = AW'(MAX_WIDTH);
        end else begin
            lat_w = AW'(cfg.image_width);
        end
        lat_h = (cfg.image_height == '0) ? CFG_HEIGHT_W'(1) : cfg.image_height;
    end

    // item classification at the input
    assign in_frame = r_in_row < {1'b0, r_act_h};
    assign skip     = in_frame && i_pix.func;
    assign do_latch = (r_in_row == '0) && (r_in_col == '0);
    assign cur_w    = do_latch ? lat_w : r_act_w;
    assign cur_h    = do_latch ? lat_h : r_act_h;
    assign pix_in   = in_frame ? i_pix.pixel : '0;

    always_comb begin
        ctrl.case_a = (r_in_col == '0) && (r_in_row >= ROW_W'(2));
        ctrl.case_b = (r_in_col != '0) && (r_in_row != '0);
        ctrl.last   = ctrl.case_a && (r_in_row == ({1'b0, cur_h} + ROW_W'(1)));
        if (ctrl.case_a) begin
            ctrl.hl = cur_w >= AW'(2);
            ctrl.ht = r_in_row >= ROW_W'(3);
        end else begin
            ctrl.hl = r_in_col >= CW'(2);
            ctrl.ht = r_in_row >= ROW_W'(2);
        end
    end

    // handshake
    assign s1_emit     = r_s1.case_a || r_s1.case_b;
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_code.ready || !s1_emit);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign acc         = i_pix.valid && i_pix.ready;
    assign s1_go       = acc && !skip;

    // next position
    assign col_p1 = AW'(r_in_col) + AW'(1);
    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (col_p1 >= cur_w) begin
            n_in_col = '0;
            n_in_row = r_in_row + ROW_W'(1);
        end else begin
            n_in_col = CW'(col_p1);
        end
        if (ctrl.last) begin
            n_in_col = '0;
            n_in_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= '0;
            r_in_col <= '0;
            r_act_w  <= AW'(ACT_W_RST);
            r_act_h  <= HEIGHT_RESET;
        end else if (s1_go) begin
            r_in_row <= n_in_row;
            r_in_col <= n_in_col;
            if (do_latch) begin
                r_act_w <= lat_w;
                r_act_h <= lat_h;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_go) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s1     <= ctrl;
            r_s1_pix <= pix_in;
            r_s1_col <= r_in_col;
        end
    end

    // line buffers: read at the input, write back when the item moves on
    lbp3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (s1_go),
        .i_rd_addr (r_in_col),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_up   (lb_mid_rd),
        .i_wr_mid  (r_s1_pix),
        .o_up_rd   (lb_up_rd),
        .o_mid_rd  (lb_mid_rd)
    );

    // neighbors; both code cases share all but the right column
    assign ctr = r_win[1][2];
    always_comb begin
        nb[7] = (r_s1.ht && r_s1.hl) ? r_win[0][1] : '0;
        nb[6] = r_s1.ht ? r_win[0][2] : '0;
        nb[5] = (r_s1.case_b && r_s1.ht) ? lb_up_rd : '0;
        nb[4] = r_s1.case_b ? lb_mid_rd : '0;
        nb[3] = r_s1.case_b ? r_s1_pix : '0;
        nb[2] = r_win[2][2];
        nb[1] = r_s1.hl ? r_win[2][1] : '0;
        nb[0] = r_s1.hl ? r_win[1][1] : '0;
        for (int k = 0; k < CODE_W; k++) begin
            code[k] = nb[k] >= ctr;
        end
    end

    // sliding window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= lb_up_rd;
            r_win[1][2] <= lb_mid_rd;
            r_win[2][2] <= r_s1_pix;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emit) begin
            r_code <= code;
            r_last <= r_s1.last;
        end
    end

    assign o_code.valid      = r_out_valid;
    assign o_code.lbp_code   = r_code;
    assign o_code.frame_last = r_last;

    // checks
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AW'(r_in_col) < r_act_w)
        else $error("column counter past active width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= ({1'b0, r_act_h} + ROW_W'(1)))
        else $error("row counter past drain end");

    a_cases_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(r_s1.case_a && r_s1.case_b))
        else $error("both code cases set");

    a_last_case_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.last) |-> r_s1.case_a)
        else $error("frame end outside column zero");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && ctrl.last) |=> (r_in_row == '0) && (r_in_col == '0))
        else $error("position not cleared after frame end");

endmodule

// ===== tb/lbp_3x3_image_stream_test.sv =====
`timescale 1ns / 1ps

module lbp_3x3_image_stream_test;
    import lbp3_pkg::*;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_SPACING = 700;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic func;
        t_pix pixel;
    } t_feed_item;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_code_exp;

    typedef enum {PIX_ANY, PIX_LOW, PIX_RAIL, PIX_MID} t_pix_mix;
    typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // config port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // stream side drive values
    logic drv_valid = 1'b0;
    logic drv_func  = FUNC_FLUSH;
    t_pix drv_pixel = '0;
    logic rx_ready  = 1'b0;

    lbp3_pix_if  pix_if ();
    lbp3_code_if code_if ();

    assign pix_if.valid  = drv_valid;
    assign pix_if.func   = drv_func;
    assign pix_if.pixel  = drv_pixel;
    assign code_if.ready = rx_ready;

    lbp_3x3_image_stream dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_if),
        .o_code  (code_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Golden LBP state
    // ---------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0]  cfg_w = WIDTH_RESET;
    logic [CFG_HEIGHT_W-1:0] cfg_h = HEIGHT_RESET;
    t_pix        upper_buf [DEF_MAX_WIDTH];
    t_pix        mid_buf   [DEF_MAX_WIDTH];
    t_pix        win [3][3];
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;
    int unsigned act_w   = 640;
    int unsigned act_h   = 480;

    t_feed_item  pixel_feed_q [$];
    t_code_exp   pending_codes [$];

    int unsigned errors      = 0;
    int unsigned items_in    = 0;
    int unsigned codes_seen  = 0;
    int unsigned frames_done = 0;
    int unsigned stim_items  = 0;

    function automatic int unsigned eff_width(input logic [CFG_WIDTH_W-1:0] w);
        if (w == 0) return 1;
        if (w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height(input logic [CFG_HEIGHT_W-1:0] h);
        return (h == 0) ? 1 : h;
    endfunction

    // one accepted transfer: slide the window, emit the code it completes
    task automatic lbp_window_step(input logic f, input t_pix px);
        t_pix              nb [8];
        t_pix              ctr;
        t_pix              p;
        logic [CODE_W-1:0] code;
        int unsigned       r;
        int unsigned       c;
        bit                hl;
        bit                ht;
        bit                emit;
        bit                last;
        t_code_exp         e;
        p    = px;
        ctr  = '0;
        emit = 1'b0;
        last = 1'b0;
        foreach (nb[k]) nb[k] = '0;
        if (row_pos < act_h) begin
            // flush ticks inside the frame or while idle do nothing
            if (f == FUNC_FLUSH) return;
            if (row_pos == 0 && col_pos == 0) begin
                act_w = eff_width(cfg_w);
                act_h = eff_height(cfg_h);
            end
        end else begin
            // drain: rows below the frame are zero, any pixel is dropped
            p = '0;
        end
        r = row_pos;
        c = col_pos;

        // start of a row: finish the last pixel of row r-2
        if (c == 0 && r >= 2) begin
            hl    = act_w >= 2;
            ht    = r >= 3;
            ctr   = win[1][2];
            nb[0] = (ht && hl) ? win[0][1] : '0;
            nb[1] = ht ? win[0][2] : '0;
            nb[5] = win[2][2];
            nb[6] = hl ? win[2][1] : '0;
            nb[7] = hl ? win[1][1] : '0;
            emit  = 1'b1;
            last  = (r == act_h + 1);
        end

        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2]    = upper_buf[c];
        win[1][2]    = mid_buf[c];
        win[2][2]    = p;
        upper_buf[c] = mid_buf[c];
        mid_buf[c]   = p;

        // interior step: center is one column left, one row up
        if (c >= 1 && r >= 1) begin
            hl    = c >= 2;
            ht    = r >= 2;
            ctr   = win[1][1];
            nb[0] = (ht && hl) ? win[0][0] : '0;
            nb[1] = ht ? win[0][1] : '0;
            nb[2] = ht ? win[0][2] : '0;
            nb[3] = win[1][2];
            nb[4] = win[2][2];
            nb[5] = win[2][1];
            nb[6] = hl ? win[2][0] : '0;
            nb[7] = hl ? win[1][0] : '0;
            emit  = 1'b1;
        end

        col_pos = c + 1;
        if (col_pos >= act_w) begin
            col_pos = 0;
            row_pos = r + 1;
        end
        if (last) begin
            row_pos = 0;
            col_pos = 0;
        end

        if (emit) begin
            code = '0;
            for (int k = 0; k < 8; k++) begin
                if (nb[k] >= ctr) code[7-k] = 1'b1;
            end
            e.code = code;
            e.last = last;
            pending_codes.push_back(e);
        end
    endtask

    // ---------------------------------------------------------------
    // Pixel driver: bursts with random gaps, golden update on transfer
    // ---------------------------------------------------------------
    int unsigned burst_left = 20;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        t_feed_item nxt;
        logic       nv;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            nv = drv_valid;
            if (drv_valid && pix_if.ready) begin
                lbp_window_step(drv_func, drv_pixel);
                items_in++;
                nv = 1'b0;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 50);
                    gap_left   = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!nv) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pixel_feed_q.size() != 0) begin
                    nxt = pixel_feed_q.pop_front();
                    drv_func  <= nxt.func;
                    drv_pixel <= nxt.pixel;
                    nv = 1'b1;
                end
            end
            drv_valid <= nv;
        end
    end

    // ---------------------------------------------------------------
    // Code receiver: changing ready patterns, plus long hold-offs
    // ---------------------------------------------------------------
    t_rx_mode    rx_mode      = RX_OPEN;
    int unsigned mode_left    = 0;
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 150;

    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            rdy = 1'b1;
            if (hold_left == 0 && codes_seen >= next_hold_at) begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_MOSTLY: rdy = $urandom_range(0, 3) != 0;
                    RX_SPARSE: rdy = $urandom_range(0, 3) == 0;
                    default:   rdy = ~rx_ready;
                endcase
            end
            rx_ready <= rdy;
        end
    end

    // ---------------------------------------------------------------
    // Code monitor: compare each transfer with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_code_exp e;
        if (i_rst_n && code_if.valid && code_if.ready) begin
            codes_seen++;
            if (code_if.frame_last) frames_done++;
            if (pending_codes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected code transfer, expected none, got code %02h last %0b",
                             $time, code_if.lbp_code, code_if.frame_last);
            end else begin
                e = pending_codes.pop_front();
                if (code_if.lbp_code !== e.code) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: lbp_code mismatch, expected %02h, got %02h",
                                 $time, e.code, code_if.lbp_code);
                end
                if (code_if.frame_last !== e.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: frame_last mismatch, expected %0b, got %0b",
                                 $time, e.last, code_if.frame_last);
                end
            end
        end
    end

    // watchdog
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d codes still expected",
                     cycle_count, pending_codes.size());
            $display("lbp_3x3_image_stream_test: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Config port and stimulus helpers
    // ---------------------------------------------------------------
    task automatic apb_cycle(input bit wr, input t_reg_idx idx,
                             input logic [APB_DATA_W-1:0] wdata,
                             output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input t_reg_idx idx);
        logic [APB_DATA_W-1:0] rd;
        logic [APB_DATA_W-1:0] exp_val;
        apb_cycle(1'b0, idx, '0, rd);
        exp_val = (idx == REG_IMAGE_WIDTH) ? APB_DATA_W'(cfg_w) : APB_DATA_W'(cfg_h);
        if (rd !== exp_val) begin
            errors++;
            $display("%0t: register %s readback mismatch, expected %0d, got %0d",
                     $time, idx.name(), exp_val, rd);
        end
    endtask

    // write a register (sometimes with junk above its width), then read it back
    task automatic cfg_set(input t_reg_idx idx, input int unsigned value);
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] rd;
        wdata = value;
        if ($urandom_range(0, 1)) begin
            if (idx == REG_IMAGE_WIDTH) wdata = wdata | ($urandom() & 32'hFFFF_F000);
            else wdata = wdata | ($urandom() & 32'hFFFF_0000);
        end
        apb_cycle(1'b1, idx, wdata, rd);
        if (idx == REG_IMAGE_WIDTH) cfg_w = wdata[CFG_WIDTH_W-1:0];
        else cfg_h = wdata[CFG_HEIGHT_W-1:0];
        check_reg(idx);
    endtask

    // block is idle: nothing queued, nothing in flight, no code owed
    task automatic wait_idle();
        while (pixel_feed_q.size() != 0 || drv_valid || pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_item(input logic f, input t_pix px);
        t_feed_item it;
        it.func  = f;
        it.pixel = px;
        pixel_feed_q.push_back(it);
    endtask

    function automatic t_pix rand_pixel(input t_pix_mix mix);
        case (mix)
            PIX_ANY:  return t_pix'($urandom_range(0, 255));
            PIX_LOW:  return t_pix'($urandom_range(0, 3));
            PIX_RAIL: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:  return t_pix'(126 + $urandom_range(0, 4));
        endcase
    endfunction

    // one frame at the current size plus its drain; noisy adds stray flushes
    // and drain pixels that the block must drop
    task automatic queue_frame(input t_pix_mix mix, input bit noisy);
        int unsigned w;
        int unsigned h;
        w = eff_width(cfg_w);
        h = eff_height(cfg_h);
        if (noisy && $urandom_range(0, 1)) push_item(FUNC_FLUSH, t_pix'($urandom()));
        for (int unsigned n = 0; n < w * h; n++) begin
            if (noisy && $urandom_range(0, 15) == 0) push_item(FUNC_FLUSH, t_pix'($urandom()));
            push_item(FUNC_PIXEL, rand_pixel(mix));
            stim_items++;
        end
        for (int unsigned n = 0; n <= w; n++) begin
            if (noisy && $urandom_range(0, 3) == 0) push_item(FUNC_PIXEL, t_pix'($urandom()));
            else push_item(FUNC_FLUSH, t_pix'($urandom()));
            stim_items++;
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        int unsigned n0;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        foreach (upper_buf[i]) begin
            upper_buf[i] = '0;
            mid_buf[i]   = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_reg(REG_IMAGE_WIDTH);
        check_reg(REG_IMAGE_HEIGHT);

        // 3x3 frame: rails, ties, a stray flush inside, a pixel in the drain
        cfg_set(REG_IMAGE_WIDTH, 3);
        cfg_set(REG_IMAGE_HEIGHT, 3);
        push_item(FUNC_FLUSH, 8'h5A);
        push_item(FUNC_PIXEL, 8'd0);
        push_item(FUNC_PIXEL, 8'd255);
        push_item(FUNC_PIXEL, 8'd7);
        push_item(FUNC_PIXEL, 8'd7);
        push_item(FUNC_FLUSH, 8'hFF);
        push_item(FUNC_PIXEL, 8'd7);
        push_item(FUNC_PIXEL, 8'd255);
        push_item(FUNC_PIXEL, 8'd0);
        push_item(FUNC_PIXEL, 8'd0);
        push_item(FUNC_PIXEL, 8'd128);
        push_item(FUNC_FLUSH, 8'h00);
        push_item(FUNC_PIXEL, 8'hA5);
        push_item(FUNC_FLUSH, 8'h00);
        push_item(FUNC_FLUSH, 8'h00);
        wait_idle();

        // single-pixel frames back to back: all neighbors outside
        cfg_set(REG_IMAGE_WIDTH, 1);
        cfg_set(REG_IMAGE_HEIGHT, 1);
        push_item(FUNC_PIXEL, 8'd255);
        push_item(FUNC_FLUSH, 8'h00);
        push_item(FUNC_FLUSH, 8'h00);
        push_item(FUNC_PIXEL, 8'd0);
        push_item(FUNC_FLUSH, 8'h00);
        push_item(FUNC_FLUSH, 8'h00);
        wait_idle();

        // zero width and height act as one
        cfg_set(REG_IMAGE_WIDTH, 0);
        cfg_set(REG_IMAGE_HEIGHT, 0);
        push_item(FUNC_PIXEL, 8'd77);
        push_item(FUNC_FLUSH, 8'h00);
        push_item(FUNC_PIXEL, 8'd200);

        // random frames, mostly small, some back to back at the same size
        n0 = stim_items;
        while (stim_items - n0 < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 6) begin
                wait_idle();
                sel = $urandom_range(0, 2);
                if (sel != 1) begin
                    if ($urandom_range(0, 19) == 0) w = 0;
                    else if ($urandom_range(0, 9) == 0) w = $urandom_range(13, 70);
                    else w = $urandom_range(1, 12);
                    cfg_set(REG_IMAGE_WIDTH, w);
                end
                if (sel != 0) begin
                    if ($urandom_range(0, 19) == 0) h = 0;
                    else if ($urandom_range(0, 9) == 0) h = $urandom_range(9, 20);
                    else h = $urandom_range(1, 8);
                    cfg_set(REG_IMAGE_HEIGHT, h);
                end
            end
            queue_frame(t_pix_mix'($urandom_range(0, 3)), $urandom_range(0, 9) < 3);
        end
        wait_idle();

        // shape extremes: one long row, then one tall column
        cfg_set(REG_IMAGE_WIDTH, 200);
        cfg_set(REG_IMAGE_HEIGHT, 1);
        queue_frame(PIX_ANY, 1'b0);
        wait_idle();
        cfg_set(REG_IMAGE_WIDTH, 1);
        cfg_set(REG_IMAGE_HEIGHT, 200);
        queue_frame(PIX_LOW, 1'b1);

        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("run covered %0d input transfers and %0d codes over %0d frames",
                 items_in, codes_seen, frames_done);
        $display("sizes from 1x1 (zero settings) to a 200-pixel row and a 200-row column");
        if (errors == 0) begin
            $display("lbp_3x3_image_stream_test: done, clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("lbp_3x3_image_stream_test: done, errors");
        end
        $finish;
    end

endmodule
